>>> rtl/upd_pkg.sv
`timescale 1ns / 1ps

package upd_pkg;

    localparam logic [7:0] CH_PLUS    = 8'h2B;
    localparam logic [7:0] CH_PERCENT = 8'h25;
    localparam logic [7:0] CH_SPACE   = 8'h20;
    localparam logic [7:0] CH_NUL     = 8'h00;

    localparam logic [7:0] HEX_UPPER_OFS = 8'd55;
    localparam logic [7:0] HEX_LOWER_OFS = 8'd87;
    localparam logic [7:0] HEX_DIGIT_OFS = 8'd48;

    // results per transaction and queue depth
    localparam int unsigned MAX_RESULTS = 2;

    typedef struct packed {
        logic [7:0] in_byte;
        logic       last_byte;
    } t_in;

    typedef struct packed {
        logic [7:0] out_byte;
        logic       is_end;
    } t_out;

    // compacted results of one decoded byte, first slot filled first
    typedef struct packed {
        logic [1:0] count;
        t_out       first;
        t_out       second;
    } t_dec;

    function automatic logic [3:0] hex_value(input logic [7:0] c);
        logic [7:0] diff;
        diff = 8'd0;
        case (c) inside
            [8'h41:8'h46]: diff = c - HEX_UPPER_OFS;
            [8'h61:8'h66]: diff = c - HEX_LOWER_OFS;
            [8'h30:8'h39]: diff = c - HEX_DIGIT_OFS;
            default:       diff = 8'd0;
        endcase
        return diff[3:0];
    endfunction

endpackage

>>> rtl/upd_decode.sv
`timescale 1ns / 1ps

module upd_decode (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  upd_pkg::t_in  i_item,
    input  logic          i_advance,
    output upd_pkg::t_dec o_dec
);

    typedef enum logic [1:0] {
        PH_PLAIN,
        PH_HIGH,
        PH_LOW,
        PH_STOP
    } t_phase;

    t_phase     r_phase, n_phase;
    logic [3:0] r_high, n_high;
    logic       has_data;
    logic [7:0] data;

    always_comb begin
        n_phase  = r_phase;
        n_high   = r_high;
        has_data = 1'b0;
        data     = i_item.in_byte;
        case (r_phase)
            PH_PLAIN: begin
                if (i_item.in_byte == upd_pkg::CH_NUL) begin
                    n_phase = PH_STOP;
                end else if (i_item.in_byte == upd_pkg::CH_PLUS) begin
                    has_data = 1'b1;
                    data     = upd_pkg::CH_SPACE;
                end else if (i_item.in_byte == upd_pkg::CH_PERCENT) begin
                    n_phase = PH_HIGH;
                end else begin
                    has_data = 1'b1;
                end
            end
            PH_HIGH: begin
                // a percent too close to the end yields nothing
                if (!i_item.last_byte) begin
                    n_high  = upd_pkg::hex_value(i_item.in_byte);
                    n_phase = PH_LOW;
                end
            end
            PH_LOW: begin
                has_data = 1'b1;
                data     = {r_high, upd_pkg::hex_value(i_item.in_byte)};
                n_phase  = PH_PLAIN;
            end
            default: begin
            end
        endcase
        if (i_item.last_byte) begin
            n_phase = PH_PLAIN;
            n_high  = 4'd0;
        end
    end

    always_comb begin
        o_dec.count           = {1'b0, has_data} + {1'b0, i_item.last_byte};
        o_dec.first.out_byte  = has_data ? data : upd_pkg::CH_NUL;
        o_dec.first.is_end    = !has_data;
        o_dec.second.out_byte = upd_pkg::CH_NUL;
        o_dec.second.is_end   = 1'b1;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= PH_PLAIN;
            r_high  <= 4'd0;
        end else if (i_advance) begin
            r_phase <= n_phase;
            r_high  <= n_high;
        end
    end

endmodule

>>> rtl/upd_out_queue.sv
`timescale 1ns / 1ps

module upd_out_queue (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  upd_pkg::t_dec i_dec,
    input  logic          i_push,
    output logic [1:0]    o_space,
    output logic          o_valid,
    input  logic          i_ready,
    output upd_pkg::t_out o_data
);

    upd_pkg::t_out r_q [upd_pkg::MAX_RESULTS];
    upd_pkg::t_out n_q [upd_pkg::MAX_RESULTS];
    logic [1:0]    r_count, n_count;
    logic [1:0]    base;
    logic [1:0]    push_n;
    logic          pop;

    assign pop     = (r_count != 2'd0) && i_ready;
    assign base    = r_count - {1'b0, pop};
    assign push_n  = i_push ? i_dec.count : 2'd0;
    assign o_space = 2'd2 - r_count;
    assign o_valid = (r_count != 2'd0);
    assign o_data  = r_q[0];

    always_comb begin
        n_q = r_q;
        if (pop) begin
            n_q[0] = r_q[1];
        end
        if (push_n != 2'd0) begin
            n_q[base[0]] = i_dec.first;
        end
        if (push_n == 2'd2) begin
            n_q[1] = i_dec.second;
        end
        n_count = base + push_n;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= 2'd0;
        end else begin
            r_count <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        r_q <= n_q;
    end

endmodule

>>> rtl/url_percent_decoder.sv
`timescale 1ns / 1ps

// url percent decoder
// input channel: one raw byte per transaction on i_in_data, with last_byte
// marking the final byte of a buffer; the buffer boundary is taken from it
// output channel: decoded bytes on o_out_data; each buffer closes with one
// transaction carrying out_byte 0 and is_end 1
// '+' becomes a space, '%' plus two hex digits becomes one byte, a nul
// where a plain character is expected drops the rest of the buffer
// an input transaction is held in the input register, and its results then
// pass through a two-entry result queue to the output
// throughput: one byte per cycle while the receiver is ready and each byte
// gives at most one result; a byte that also closes a buffer gives two
// results and waits for an empty queue, so in a full-rate stream it stalls
// the input and leaves a gap in the output
// the input register advances only when the result queue has room for all
// results of its byte, so a stalled receiver backs up into o_in_ready after
// at most three bytes are held
// reset empties the input register and queue and returns the decoder to
// expecting a plain character
module url_percent_decoder (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_in_valid,
    output logic          o_in_ready,
    input  upd_pkg::t_in  i_in_data,
    output logic          o_out_valid,
    input  logic          i_out_ready,
    output upd_pkg::t_out o_out_data
);

    logic          r_in_valid;
    upd_pkg::t_in  r_in;
    upd_pkg::t_dec dec;
    logic [1:0]    space;
    logic          advance;

    assign advance    = r_in_valid && (dec.count <= space);
    assign o_in_ready = !r_in_valid || advance;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (o_in_ready) begin
            r_in_valid <= i_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_in_ready && i_in_valid) begin
            r_in <= i_in_data;
        end
    end

    upd_decode u_decode (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_item    (r_in),
        .i_advance (advance),
        .o_dec     (dec)
    );

    upd_out_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_dec   (dec),
        .i_push  (advance),
        .o_space (space),
        .o_valid (o_out_valid),
        .i_ready (i_out_ready),
        .o_data  (o_out_data)
    );

`ifndef SYNTHESIS
    // a byte that closes a buffer always produces its terminator
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        advance && r_in.last_byte |-> dec.count != 2'd0)
        else $error("closing byte produced no terminator");

    // the terminator transaction carries a zero byte
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_out_data.is_end |-> o_out_data.out_byte == 8'd0)
        else $error("terminator with nonzero byte");

    // queue never holds more than it was sized for
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        space != 2'd3)
        else $error("result queue overflow");

    // a held input byte with room in an empty queue must advance
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_in_valid && space == 2'd2 |-> advance)
        else $error("input register stuck with empty queue");
`endif

endmodule
